FILE: design/atbd_pkg.sv
// atbd_pkg: shared types and constants for the adaptive threshold beat detector
// no dependencies; used by atbd_apb_regs, atbd_update and the top level
`timescale 1ns / 1ps

package atbd_pkg;

  localparam int unsigned PaddrW = 5;
  localparam int unsigned PdataW = 32;

  // register word indexes, paddr[4:2]
  typedef enum logic [2:0] {
    RegAvgInterval = 3'd0,
    RegRefractory  = 3'd1,
    RegMinPeak     = 3'd2,
    RegDecayFactor = 3'd3,
    RegHoldSamples = 3'd4
  } reg_idx_e;

  localparam logic [15:0] AvgIntervalRst = 16'd100;
  localparam logic [15:0] RefractoryRst  = 16'd250;
  localparam logic [15:0] MinPeakRst     = 16'd9830;
  localparam logic [15:0] DecayFactorRst = 16'd64880;
  localparam logic [7:0]  HoldSamplesRst = 8'd40;

  // exact floor(x / 10) for x < 2^22 as (x * Recip10) >> Recip10Shift
  localparam logic [19:0] Recip10      = 20'd838861;
  localparam int unsigned Recip10Shift = 23;

  typedef struct packed {
    logic [15:0] avg_interval_ms;
    logic [15:0] refractory_ms;
    logic [15:0] min_peak;
    logic [15:0] decay_factor;
    logic [7:0]  hold_samples;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [15:0] peak_level;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        beat_detected;
    logic [15:0] beat_count;
    logic [15:0] beat_peak;
    logic        any_beats;
  } result_t;

endpackage

FILE: design/atbd_apb_regs.sv
// atbd_apb_regs: apb configuration registers of the beat detector
// depends on atbd_pkg
`timescale 1ns / 1ps

module atbd_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [atbd_pkg::PaddrW-1:0]    paddr,
  input  logic [atbd_pkg::PdataW-1:0]    pwdata,
  output logic [atbd_pkg::PdataW-1:0]    prdata,
  output logic                           pready,
  output atbd_pkg::cfg_t                 cfg_o
);

  atbd_pkg::cfg_t     cfg_q;
  atbd_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = atbd_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.avg_interval_ms <= atbd_pkg::AvgIntervalRst;
      cfg_q.refractory_ms   <= atbd_pkg::RefractoryRst;
      cfg_q.min_peak        <= atbd_pkg::MinPeakRst;
      cfg_q.decay_factor    <= atbd_pkg::DecayFactorRst;
      cfg_q.hold_samples    <= atbd_pkg::HoldSamplesRst;
    end else if (wr_en) begin
      case (idx)
        atbd_pkg::RegAvgInterval: cfg_q.avg_interval_ms <= pwdata[15:0];
        atbd_pkg::RegRefractory:  cfg_q.refractory_ms   <= pwdata[15:0];
        atbd_pkg::RegMinPeak:     cfg_q.min_peak        <= pwdata[15:0];
        atbd_pkg::RegDecayFactor: cfg_q.decay_factor    <= pwdata[15:0];
        atbd_pkg::RegHoldSamples: cfg_q.hold_samples    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      atbd_pkg::RegAvgInterval: prdata = {16'd0, cfg_q.avg_interval_ms};
      atbd_pkg::RegRefractory:  prdata = {16'd0, cfg_q.refractory_ms};
      atbd_pkg::RegMinPeak:     prdata = {16'd0, cfg_q.min_peak};
      atbd_pkg::RegDecayFactor: prdata = {16'd0, cfg_q.decay_factor};
      atbd_pkg::RegHoldSamples: prdata = {24'd0, cfg_q.hold_samples};
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/atbd_update.sv
// atbd_update: detector state registers and the single-pass update logic
// depends on atbd_pkg
`timescale 1ns / 1ps

module atbd_update #(
  parameter int unsigned AVERAGE_DIVISOR = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  atbd_pkg::cfg_t    cfg_i,
  input  atbd_pkg::item_t   item_i,
  output atbd_pkg::result_t result_o
);

  // average by reciprocal: sum below 2^16 * divisor, else saturate
  localparam int unsigned L      = $clog2(AVERAGE_DIVISOR);
  localparam int unsigned XW     = 16 + L;
  localparam int unsigned RW     = 18 + L;
  localparam int unsigned K      = 16 + 2 * L;
  localparam longint unsigned RecipL =
    ((64'd1 << K) + 64'(AVERAGE_DIVISOR) - 64'd1) / 64'(AVERAGE_DIVISOR);
  localparam logic [RW-1:0] Recip = RecipL[RW-1:0];
  localparam logic [32:0] SatLimit = 33'(AVERAGE_DIVISOR) << 16;

  logic [31:0] running_sum_q, running_sum_d;
  logic [15:0] average_q, average_d;
  logic [15:0] cutoff_q, cutoff_d;
  logic [7:0]  hold_q, hold_d;
  logic [31:0] last_beat_time_q, last_beat_time_d;
  logic [31:0] interval_start_q, interval_start_d;
  logic [15:0] beat_counter_q, beat_counter_d;
  logic [15:0] last_beat_level_q, last_beat_level_d;

  logic              avg_update;
  logic [XW+RW-1:0]  avg_prod;
  logic [15:0]       avg_new;
  logic [15:0]       avg_eff;
  logic [31:0]       sum_base;
  logic [32:0]       sum_add;
  logic              beat;
  logic [19:0]       gain_x;
  logic [39:0]       gain_prod;
  logic [16:0]       gain_q10;
  logic [15:0]       cutoff_beat;
  logic [31:0]       decay_prod;
  logic [15:0]       cutoff_decay;

  always_comb begin
    avg_update = (item_i.now_ms - interval_start_q) >= {16'd0, cfg_i.avg_interval_ms};
    avg_prod   = {{RW{1'b0}}, running_sum_q[XW-1:0]} * {{XW{1'b0}}, Recip};
    if ({1'b0, running_sum_q} >= SatLimit) begin
      avg_new = 16'hFFFF;
    end else begin
      avg_new = avg_prod[K +: 16];
    end
    avg_eff  = avg_update ? avg_new : average_q;
    sum_base = avg_update ? 32'd0 : running_sum_q;
    sum_add  = {1'b0, sum_base} + {17'd0, item_i.peak_level};

    beat = ((item_i.now_ms - last_beat_time_q) > {16'd0, cfg_i.refractory_ms})
        && (item_i.peak_level > cutoff_q)
        && (item_i.peak_level > cfg_i.min_peak)
        && (item_i.peak_level > avg_eff);

    // 1.1 * peak rounded half up: (11 * peak + 5) / 10
    gain_x      = ({4'd0, item_i.peak_level} << 3) + ({4'd0, item_i.peak_level} << 1)
                + {4'd0, item_i.peak_level} + 20'd5;
    gain_prod   = {20'd0, gain_x} * {20'd0, atbd_pkg::Recip10};
    gain_q10    = gain_prod[atbd_pkg::Recip10Shift +: 17];
    cutoff_beat = gain_q10[16] ? 16'hFFFF : gain_q10[15:0];

    decay_prod   = {16'd0, cutoff_q} * {16'd0, cfg_i.decay_factor};
    cutoff_decay = (decay_prod[31:16] < cfg_i.min_peak) ? cfg_i.min_peak : decay_prod[31:16];

    running_sum_d     = running_sum_q;
    average_d         = average_q;
    cutoff_d          = cutoff_q;
    hold_d            = hold_q;
    last_beat_time_d  = last_beat_time_q;
    interval_start_d  = interval_start_q;
    beat_counter_d    = beat_counter_q;
    last_beat_level_d = last_beat_level_q;

    if (item_i.action) begin
      beat_counter_d           = 16'd0;
      result_o.beat_detected   = 1'b0;
      result_o.beat_count      = beat_counter_q;
      result_o.beat_peak       = last_beat_level_q;
      result_o.any_beats       = beat_counter_q != 16'd0;
    end else begin
      average_d     = avg_eff;
      running_sum_d = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
      if (avg_update) begin
        interval_start_d = item_i.now_ms;
      end
      if (beat) begin
        beat_counter_d    = (beat_counter_q == 16'hFFFF) ? 16'd1 : beat_counter_q + 16'd1;
        last_beat_level_d = item_i.peak_level;
        cutoff_d          = cutoff_beat;
        last_beat_time_d  = item_i.now_ms;
        hold_d            = 8'd0;
      end else if (hold_q <= cfg_i.hold_samples) begin
        if (hold_q != 8'hFF) begin
          hold_d = hold_q + 8'd1;
        end
      end else begin
        cutoff_d = cutoff_decay;
      end
      result_o.beat_detected = beat;
      result_o.beat_count    = beat_counter_d;
      result_o.beat_peak     = last_beat_level_d;
      result_o.any_beats     = beat_counter_d != 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q     <= '0;
      average_q         <= '0;
      cutoff_q          <= '0;
      hold_q            <= '0;
      last_beat_time_q  <= '0;
      interval_start_q  <= '0;
      beat_counter_q    <= '0;
      last_beat_level_q <= '0;
    end else if (advance_i) begin
      running_sum_q     <= running_sum_d;
      average_q         <= average_d;
      cutoff_q          <= cutoff_d;
      hold_q            <= hold_d;
      last_beat_time_q  <= last_beat_time_d;
      interval_start_q  <= interval_start_d;
      beat_counter_q    <= beat_counter_d;
      last_beat_level_q <= last_beat_level_d;
    end
  end

endmodule

FILE: design/adaptive_threshold_beat_detector_core.sv
// adaptive_threshold_beat_detector_core: top level of the adaptive threshold beat detector
// depends on atbd_pkg, atbd_apb_regs and atbd_update
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------------------
//  in        sink       in_valid_i / in_ready_o   action_i, peak_level_i, now_ms_i
//  out       source     out_valid_o / out_ready_i beat_detected_o, beat_count_o,
//                                                  beat_peak_o, any_beats_o
//  cfg       apb slave  psel / penable / pready   paddr, pwdata, pwrite, prdata
//
//  one beat per cycle sustained while out_ready_i does not hold the result register; a result is
//  valid in the cycle after its beat is taken by the update stage, and each beat passes in turn
//  through the input register and then, by the single-pass update, into the result register
//  the update stage sustains the rate because state is read and written in the same cycle
//  reset clears the state, both valid flags and loads the register defaults; no clearing pass
//  when the result register is held the input register keeps its beat and in_ready_o drops

module adaptive_threshold_beat_detector_core #(
  parameter int unsigned AVERAGE_DIVISOR = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input beats
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [15:0]                 peak_level_i,
  input  logic [31:0]                 now_ms_i,
  // result beats
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        beat_detected_o,
  output logic [15:0]                 beat_count_o,
  output logic [15:0]                 beat_peak_o,
  output logic                        any_beats_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [atbd_pkg::PaddrW-1:0] paddr,
  input  logic [atbd_pkg::PdataW-1:0] pwdata,
  output logic [atbd_pkg::PdataW-1:0] prdata,
  output logic                        pready
);

  atbd_pkg::cfg_t    cfg;
  atbd_pkg::item_t   in_item_q;
  atbd_pkg::result_t result_d, result_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;

  atbd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // held beat moves into the update stage when the result register is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q.action     <= action_i;
      in_item_q.peak_level <= peak_level_i;
      in_item_q.now_ms     <= now_ms_i;
    end
  end

  atbd_update #(
    .AVERAGE_DIVISOR (AVERAGE_DIVISOR)
  ) u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cfg_i     (cfg),
    .item_i    (in_item_q),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign beat_detected_o = result_q.beat_detected;
  assign beat_count_o    = result_q.beat_count;
  assign beat_peak_o     = result_q.beat_peak;
  assign any_beats_o     = result_q.any_beats;

  // a detected beat always leaves a nonzero count
  a_beat_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beat_detected_o |-> any_beats_o && (beat_count_o != 16'd0))
    else $error("beat reported with zero count");

  // a beat peak lies above the floor, so it is never zero
  a_beat_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beat_detected_o |-> beat_peak_o != 16'd0)
    else $error("beat reported with zero peak");

  // the input side stalls only while the result register is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with free result register");

  // a stalled beat in the input register still sits there next cycle
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_item_q))
    else $error("held beat lost from input register");

endmodule
